>>> rtl/core/gel_pkg.sv
// Shared types, constants and helper functions for the graph header and edge line parser.
// No dependencies; included by every module of the block through a wildcard import.
package gel_pkg;

  localparam int unsigned LenW = 12;
  localparam int unsigned NumW = 32;

  localparam logic [7:0] NewlineByte = 8'd10;
  localparam logic [7:0] SpaceByte   = 8'd32;
  localparam logic [7:0] DigitZero   = 8'h30;
  localparam logic [7:0] DigitNine   = 8'h39;

  localparam logic [LenW-1:0] LongestLineReset = 12'd80;

  // Token index that marks a surplus token, per line kind.
  localparam logic [2:0] ProblemSurplus = 3'd4;
  localparam logic [2:0] EdgeSurplus    = 3'd3;

  // Line kinds as sampled from the command bit.
  localparam logic KindProblem = 1'b0;
  localparam logic KindEdge    = 1'b1;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusMalformed = 2'd1,
    StatusTooLong   = 2'd2
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [NumW-1:0]     first_number;
    logic [NumW-1:0]     second_number;
  } gel_result_t;

  // Length of the keyword expected at a token, zero when the token is a number.
  function automatic logic [2:0] kw_len(input logic kind, input logic [2:0] tok);
    logic [2:0] len;
    len = 3'd0;
    if (kind == KindProblem) begin
      if (tok == 3'd0) len = 3'd1;
      else if (tok == 3'd1) len = 3'd4;
    end else if (tok == 3'd0) begin
      len = 3'd1;
    end
    return len;
  endfunction

  // Expected keyword character at a position; only meaningful below kw_len.
  function automatic logic [7:0] kw_char(input logic kind, input logic [2:0] tok,
                                         input logic [1:0] pos);
    logic [7:0] ch;
    ch = "e";
    if (kind == KindProblem && tok == 3'd0) begin
      ch = "p";
    end else if (kind == KindProblem) begin
      case (pos)
        2'd0:    ch = "e";
        2'd1:    ch = "d";
        2'd2:    ch = "g";
        2'd3:    ch = "e";
        default: ch = "e";
      endcase
    end
    return ch;
  endfunction

  // value * 10 + digit, saturating at the all-ones value.
  function automatic logic [NumW-1:0] add_digit(input logic [NumW-1:0] v,
                                                input logic [3:0] d);
    logic [NumW+3:0] t;
    t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {{NumW{1'b0}}, d};
    return (t[NumW+3:NumW] != 4'd0) ? {NumW{1'b1}} : t[NumW-1:0];
  endfunction

endpackage

>>> rtl/core/graph_header_edge_line_parser.sv
// Top level of the graph header and edge line parser: input register, line state, result register.
// Depends on gel_pkg and gel_line_fsm.
//
// Usage: text enters one byte per item on the in channel (char_byte_i, with
// command_i giving the line kind at a line's first byte). Each newline byte
// produces one result item on the out channel: a status and two numbers.
// Other bytes produce no result. The cfg channel writes the longest line
// limit; it is always ready and should only be written while the block is idle.
//
// Throughput is one byte per cycle while no newline waits on a full result
// register. A byte is held in the input register, where the line state is
// updated, and a newline's result then moves into the result register that
// drives the out channel. The result register holds one result; while it waits for
// out_ready_i, bytes that give no result keep flowing, and the next newline
// stalls in the input register, which then drops in_ready_o.
//
// Reset clears the line state to the start of a line, empties both registers
// and sets the limit to 80 bytes.
module graph_header_edge_line_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                char_byte_i,
  input  logic                      command_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gel_pkg::LenW-1:0]  longest_line_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [gel_pkg::NumW-1:0]  first_number_o,
  output logic [gel_pkg::NumW-1:0]  second_number_o
);
  import gel_pkg::*;

  logic            s1_valid_q;
  logic [7:0]      s1_char_q;
  logic            s1_cmd_q;
  logic [LenW-1:0] longest_q;
  logic            out_valid_q;
  gel_result_t     out_q;

  logic        res_valid;
  gel_result_t res;
  logic        out_free;
  logic        s1_fire;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_fire     = s1_valid_q && (!res_valid || out_free);
  assign in_ready_o  = !s1_valid_q || s1_fire;

  gel_line_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (s1_fire),
    .char_byte_i    (s1_char_q),
    .command_i      (s1_cmd_q),
    .longest_line_i (longest_q),
    .result_valid_o (res_valid),
    .result_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      longest_q <= LongestLineReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      longest_q <= longest_line_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_char_q <= char_byte_i;
      s1_cmd_q  <= command_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign first_number_o  = out_q.first_number;
  assign second_number_o = out_q.second_number;

endmodule

>>> rtl/core/gel_line_fsm.sv
// Per-line parse state and its update for one text byte.
// Depends on gel_pkg for constants, the result struct and keyword helpers.
module gel_line_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                char_byte_i,
  input  logic                      command_i,
  input  logic [gel_pkg::LenW-1:0]  longest_line_i,
  output logic                      result_valid_o,
  output gel_pkg::gel_result_t      result_o
);
  import gel_pkg::*;

  logic            line_kind_q, line_kind_d;
  logic            at_start_q, at_start_d;
  logic [2:0]      token_index_q, token_index_d;
  logic [2:0]      char_in_token_q, char_in_token_d;
  logic            malformed_q, malformed_d;
  logic            too_long_q, too_long_d;
  logic [LenW-1:0] line_length_q, line_length_d;
  logic [NumW-1:0] left_value_q, left_value_d;
  logic [NumW-1:0] right_value_q, right_value_d;

  logic       kind;
  logic [2:0] len;
  logic       is_kw;
  logic       end_bad;
  logic       is_newline;
  logic       is_digit;
  logic [2:0] surplus;
  logic [2:0] first_tok;
  logic [3:0] digit;

  assign kind       = at_start_q ? command_i : line_kind_q;
  assign len        = kw_len(kind, token_index_q);
  assign is_kw      = (len != 3'd0);
  assign end_bad    = is_kw && (char_in_token_q != len);
  assign is_newline = (char_byte_i == NewlineByte);
  assign is_digit   = (char_byte_i >= DigitZero) && (char_byte_i <= DigitNine);
  assign surplus    = (kind == KindProblem) ? ProblemSurplus : EdgeSurplus;
  assign first_tok  = (kind == KindProblem) ? 3'd2 : 3'd1;
  assign digit      = char_byte_i[3:0];

  assign result_valid_o = is_newline;

  always_comb begin
    if (too_long_q) begin
      result_o = '{status: StatusTooLong, first_number: '0, second_number: '0};
    end else if (malformed_q || end_bad) begin
      result_o = '{status: StatusMalformed, first_number: '0, second_number: '0};
    end else begin
      result_o = '{status: StatusOk, first_number: left_value_q,
                   second_number: right_value_q};
    end
  end

  always_comb begin
    line_kind_d     = kind;
    at_start_d      = 1'b0;
    token_index_d   = token_index_q;
    char_in_token_d = char_in_token_q;
    malformed_d     = malformed_q;
    too_long_d      = too_long_q;
    line_length_d   = line_length_q;
    left_value_d    = left_value_q;
    right_value_d   = right_value_q;

    if (is_newline) begin
      at_start_d      = 1'b1;
      token_index_d   = '0;
      char_in_token_d = '0;
      malformed_d     = 1'b0;
      too_long_d      = 1'b0;
      line_length_d   = '0;
      left_value_d    = '0;
      right_value_d   = '0;
    end else begin
      if (line_length_q >= longest_line_i) begin
        too_long_d = 1'b1;
      end else begin
        line_length_d = line_length_q + 1'b1;
      end

      // After a fault the rest of the line only counts toward its length.
      if (!malformed_q) begin
        if (char_byte_i == SpaceByte) begin
          char_in_token_d = '0;
          if (token_index_q + 3'd1 >= surplus) begin
            malformed_d   = 1'b1;
            token_index_d = surplus;
          end else begin
            malformed_d   = end_bad;
            token_index_d = token_index_q + 3'd1;
          end
        end else if (is_kw) begin
          if (char_in_token_q >= len ||
              char_byte_i != kw_char(kind, token_index_q, char_in_token_q[1:0])) begin
            malformed_d = 1'b1;
          end else begin
            char_in_token_d = char_in_token_q + 3'd1;
          end
        end else if (!is_digit) begin
          malformed_d = 1'b1;
        end else if (token_index_q == first_tok) begin
          left_value_d = add_digit(left_value_q, digit);
        end else begin
          right_value_d = add_digit(right_value_q, digit);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_kind_q     <= KindProblem;
      at_start_q      <= 1'b1;
      token_index_q   <= '0;
      char_in_token_q <= '0;
      malformed_q     <= 1'b0;
      too_long_q      <= 1'b0;
      line_length_q   <= '0;
      left_value_q    <= '0;
      right_value_q   <= '0;
    end else if (step_i) begin
      line_kind_q     <= line_kind_d;
      at_start_q      <= at_start_d;
      token_index_q   <= token_index_d;
      char_in_token_q <= char_in_token_d;
      malformed_q     <= malformed_d;
      too_long_q      <= too_long_d;
      line_length_q   <= line_length_d;
      left_value_q    <= left_value_d;
      right_value_q   <= right_value_d;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for graph_header_edge_line_parser: byte stream in, one result per line.
// Depends on gel_pkg for the status codes, byte constants and the result layout.
module tb_top;
  import gel_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic [7:0]       char_byte = 8'd0;
  logic             command = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [LenW-1:0]  cfg_limit = LongestLineReset;
  logic             out_ready = 1'b0;
  logic             in_ready_o;
  logic             cfg_ready_o;
  logic             out_valid_o;
  logic [1:0]       status_o;
  logic [NumW-1:0]  first_number_o;
  logic [NumW-1:0]  second_number_o;

  int send_idle_pct = 32;
  int recv_idle_pct = 48;
  int mismatches = 0;

  // Line parser state as the block should hold it.
  logic [LenW-1:0]  line_limit;
  logic             line_kind;
  logic             at_line_start;
  int               token_index;
  int               char_in_token;
  logic             line_bad;
  logic             line_too_long;
  logic [LenW-1:0]  line_length;
  logic [NumW-1:0]  left_value;
  logic [NumW-1:0]  right_value;

  gel_result_t      expected_lines[$];
  gel_result_t      oldest_line;
  logic [7:0]       line_buf[$];

  graph_header_edge_line_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .char_byte_i     (char_byte),
    .command_i       (command),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .longest_line_i  (cfg_limit),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .status_o        (status_o),
    .first_number_o  (first_number_o),
    .second_number_o (second_number_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (expected_lines.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: status %0d first %0d second %0d",
                   status_o, first_number_o, second_number_o);
        end
        mismatches++;
      end else begin
        oldest_line = expected_lines.pop_front();
        if (status_o !== oldest_line.status || first_number_o !== oldest_line.first_number ||
            second_number_o !== oldest_line.second_number) begin
          if (mismatches < 10) begin
            $display({"mismatch: expected status %0d first %0d second %0d, ",
                      "got status %0d first %0d second %0d"},
                     oldest_line.status, oldest_line.first_number, oldest_line.second_number,
                     status_o, first_number_o, second_number_o);
          end
          mismatches++;
        end
      end
    end
  end

  function automatic string keyword_for(input logic kind, input int tok);
    if (kind == KindProblem) begin
      if (tok == 0) return "p";
      if (tok == 1) return "edge";
      return "";
    end
    return (tok == 0) ? "e" : "";
  endfunction

  function automatic logic [NumW-1:0] shift_in_digit(input logic [NumW-1:0] v, input int d);
    logic [63:0] t;
    t = 64'(v) * 64'd10 + 64'(d);
    return (t > 64'hFFFF_FFFF) ? {NumW{1'b1}} : t[NumW-1:0];
  endfunction

  function automatic void clear_line_state();
    at_line_start = 1'b1;
    token_index   = 0;
    char_in_token = 0;
    line_bad      = 1'b0;
    line_too_long = 1'b0;
    line_length   = '0;
    left_value    = '0;
    right_value   = '0;
  endfunction

  // A keyword token must hold all of its characters when it ends.
  function automatic void close_token();
    string kw;
    kw = keyword_for(line_kind, token_index);
    if (kw.len() != 0 && char_in_token != kw.len()) line_bad = 1'b1;
  endfunction

  function automatic void parse_byte(input logic [7:0] ch, input logic cmd);
    string kw;
    int surplus;
    gel_result_t res;
    if (at_line_start) begin
      line_kind = cmd;
      at_line_start = 1'b0;
    end
    if (ch == NewlineByte) begin
      if (!line_bad) close_token();
      res.first_number = '0;
      res.second_number = '0;
      if (line_too_long) begin
        res.status = StatusTooLong;
      end else if (line_bad) begin
        res.status = StatusMalformed;
      end else begin
        res.status = StatusOk;
        res.first_number = left_value;
        res.second_number = right_value;
      end
      expected_lines.push_back(res);
      clear_line_state();
      return;
    end
    if (line_length >= line_limit) line_too_long = 1'b1;
    else line_length++;
    if (line_bad) return;
    if (ch == SpaceByte) begin
      surplus = (line_kind == KindProblem) ? int'(ProblemSurplus) : int'(EdgeSurplus);
      close_token();
      if (token_index + 1 >= surplus) begin
        line_bad = 1'b1;
        token_index = surplus;
      end else begin
        token_index++;
      end
      char_in_token = 0;
    end else begin
      kw = keyword_for(line_kind, token_index);
      if (kw.len() != 0) begin
        if (char_in_token >= kw.len() || ch != kw[char_in_token]) line_bad = 1'b1;
        else char_in_token++;
      end else if (ch < DigitZero || ch > DigitNine) begin
        line_bad = 1'b1;
      end else if (token_index == ((line_kind == KindProblem) ? 2 : 1)) begin
        left_value = shift_in_digit(left_value, int'(ch - DigitZero));
      end else begin
        right_value = shift_in_digit(right_value, int'(ch - DigitZero));
      end
    end
  endfunction

  // Valid stays high from one item to the next unless the sender takes a gap.
  task automatic push_char(input logic [7:0] ch, input logic cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    char_byte <= ch;
    command   <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    parse_byte(ch, cmd);
  endtask

  // The command bit only matters on a line's first byte; the rest carry noise.
  task automatic send_line(input logic cmd);
    foreach (line_buf[i]) push_char(line_buf[i], (i == 0) ? cmd : 1'($urandom_range(1)));
  endtask

  task automatic send_text(input string s, input logic cmd);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line(cmd);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_longest_line(input logic [LenW-1:0] limit);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_limit <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    line_limit = limit;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 32; recv_idle_pct = 48; end
      1: begin send_idle_pct = 48; recv_idle_pct = 32; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // Mostly well-formed lines with random numbers; some get mangled afterwards.
  task automatic build_random_line(output logic cmd);
    string kw;
    logic kind;
    int full;
    int ntok;
    int ndig;
    kind = 1'($urandom_range(1));
    full = (kind == KindProblem) ? 4 : 3;
    ntok = ($urandom_range(99) < 15) ? $urandom_range(full) : full;
    line_buf.delete();
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) line_buf.push_back(SpaceByte);
      kw = keyword_for(kind, t);
      if (kw.len() != 0) begin
        if ($urandom_range(99) < 8) begin
          repeat ($urandom_range(1, 5)) line_buf.push_back(8'($urandom_range(8'h61, 8'h7a)));
        end else begin
          for (int i = 0; i < kw.len(); i++) line_buf.push_back(kw[i]);
        end
      end else begin
        ndig = ($urandom_range(99) < 70) ? $urandom_range(1, 6) : $urandom_range(0, 12);
        repeat (ndig) line_buf.push_back(8'(DigitZero + $urandom_range(9)));
      end
    end
    if ($urandom_range(99) < 8) begin
      line_buf.push_back(SpaceByte);
      repeat ($urandom_range(1, 3)) line_buf.push_back(8'(DigitZero + $urandom_range(9)));
    end
    if ($urandom_range(99) < 6 && line_buf.size() > 0) begin
      line_buf.insert($urandom_range(line_buf.size() - 1), SpaceByte);
    end
    if ($urandom_range(99) < 8 && line_buf.size() > 0) begin
      line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
    end
    line_buf.push_back(NewlineByte);
    cmd = ($urandom_range(99) < 10) ? ~kind : kind;
  endtask

  task automatic test_directed_lines();
    send_text("\n", KindProblem);
    send_text("p\n", KindProblem);
    send_text("e 3\n", KindEdge);
    send_text("e 1 2 \n", KindEdge);
    send_text("e 42949672950 7\n", KindEdge);
    send_text("p edge 4294967295 9\n", KindProblem);
    line_buf = '{8'h65, 8'hFF, NewlineByte};
    send_line(KindEdge);
    line_buf = '{8'h70, 8'h00, NewlineByte};
    send_line(KindProblem);
  endtask

  task automatic test_limit_extremes();
    write_longest_line(12'd1);
    send_text("e\n", KindEdge);
    send_text("e 1\n", KindEdge);
    // Too long and malformed at once must report too long.
    send_text("xy\n", KindEdge);
    write_longest_line(12'd4095);
    send_text("p edge 12 34\n", KindProblem);
    write_longest_line(12'd60);
    // Leading zeros give a well-formed line of exactly the limit, then one byte over.
    for (int extra = 0; extra < 2; extra++) begin
      line_buf.delete();
      line_buf.push_back(8'h65);
      line_buf.push_back(SpaceByte);
      repeat (58 + extra) line_buf.push_back(DigitZero);
      line_buf.push_back(NewlineByte);
      send_line(KindEdge);
    end
  endtask

  task automatic test_random_lines();
    logic cmd;
    int sent;
    for (int mode = 0; mode < 3; mode++) begin
      set_idling(mode);
      for (int sub = 0; sub < 2; sub++) begin
        write_longest_line((sub == 0) ? 12'($urandom_range(6, 40)) : 12'($urandom_range(41, 4095)));
        sent = 0;
        while (sent < 170) begin
          build_random_line(cmd);
          sent += line_buf.size();
          send_line(cmd);
        end
      end
    end
  endtask

  initial begin
    line_limit = LongestLineReset;
    line_kind  = KindProblem;
    clear_line_state();
    set_idling(0);
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_directed_lines();
    test_limit_extremes();
    test_random_lines();
    wait_for_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
